// File: src/bhtag_pkg.sv
// Shared types and constants for the boundary-tag heap allocator.
// No dependencies; used by bhtag_ram and boundary_tag_heap_allocator.
package bhtag_pkg;

   localparam int HEAP_BYTES_DEF = 65536;
   localparam int WORD_BYTES     = 4;
   localparam int CHUNK_RESET    = 4096;
   localparam int LIMIT_RESET    = 65536;
   localparam int OUT_SPAN       = 65536;
   localparam int MIN_BLOCK      = 16;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_NOMEM = 2'd1;
   localparam logic [1:0] ST_ZERO  = 2'd2;

   localparam logic CSR_CHUNK = 1'b0;
   localparam logic CSR_LIMIT = 1'b1;

   typedef struct packed {
      logic read;
      logic write;
   } tag_cmd_type;

   function automatic logic [31:0] tsize(input logic [31:0] w);
      tsize = {w[31:3], 3'b000};
   endfunction

endpackage

// File: src/bhtag_ram.sv
// Tag word store: single-port synchronous memory with a registered read.
// Depends on bhtag_pkg for the command struct.
module bhtag_ram #(
   parameter int DEPTH = bhtag_pkg::HEAP_BYTES_DEF / bhtag_pkg::WORD_BYTES,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                    clock,
   input  bhtag_pkg::tag_cmd_type  cmd,
   input  logic [AW-1:0]           addr,
   input  logic [31:0]             wdata,
   output logic [31:0]             rdata
);
   logic [31:0] mem [DEPTH];
   logic [31:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (cmd.write) begin
         mem[addr] <= wdata;
      end
      if (cmd.read) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// File: src/boundary_tag_heap_allocator.sv
// Boundary-tag heap allocator top level: request sequencer, config registers.
// Depends on bhtag_pkg and bhtag_ram.
//
// An allocate walks the blocks first-fit, reading one header per step, grows the heap
// and coalesces when no block fits, then places the block; a free clears the allocated
// bits and coalesces; a zero-size allocate or a free of offset zero is answered from idle.
// One request is in flight at a time; the tag memory port sets the pace.
// Reset: a clearing pass zeroes every tag word, then the prologue and epilogue are
// written and, if it fits the limit, the first chunk is built before requests.
module boundary_tag_heap_allocator #(
   parameter int HEAP_BYTES = bhtag_pkg::HEAP_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [15:0] req_request_bytes,
   input  logic [15:0] req_block_offset,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_result_offset,
   output logic [1:0]  rsp_status,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [16:0] csr_wdata
);
   localparam int TAG_DEPTH = HEAP_BYTES / bhtag_pkg::WORD_BYTES;
   localparam int AW        = $clog2(TAG_DEPTH);
   localparam int LIM_CAP   = (HEAP_BYTES < bhtag_pkg::OUT_SPAN) ? HEAP_BYTES
                                                                 : bhtag_pkg::OUT_SPAN;
   localparam int RST_LIM   = (bhtag_pkg::LIMIT_RESET < LIM_CAP) ? bhtag_pkg::LIMIT_RESET
                                                                 : LIM_CAP;
   localparam int INIT_WORDS = bhtag_pkg::CHUNK_RESET / 4;
   localparam int INIT_SIZE  = (INIT_WORDS + (INIT_WORDS % 2)) * 4;
   localparam bit INIT_GROW  = (16 + INIT_SIZE) <= RST_LIM;

   // sequencer states
   localparam logic [5:0] S_CLEAR = 6'd0,  S_INIT1 = 6'd1,  S_INIT2 = 6'd2,
                          S_INIT3 = 6'd3,  S_IDLE  = 6'd4,  S_F0    = 6'd5,
                          S_F1    = 6'd6,  S_F2    = 6'd7,  S_FIT   = 6'd8,
                          S_FIT1  = 6'd9,  S_EXT   = 6'd10, S_G0    = 6'd11,
                          S_G1    = 6'd12, S_G2    = 6'd13, S_M0    = 6'd14,
                          S_M1    = 6'd15, S_M2    = 6'd16, S_M3    = 6'd17,
                          S_A0    = 6'd18, S_A1    = 6'd19, S_A2    = 6'd20,
                          S_B0    = 6'd21, S_B1    = 6'd22, S_B2    = 6'd23,
                          S_B3    = 6'd24, S_B4    = 6'd25, S_B5    = 6'd26,
                          S_C0    = 6'd27, S_C1    = 6'd28, S_C2    = 6'd29,
                          S_C3    = 6'd30, S_C4    = 6'd31, S_C5    = 6'd32,
                          S_C6    = 6'd33, S_MRET  = 6'd34, S_P0    = 6'd35,
                          S_P1    = 6'd36, S_P2    = 6'd37, S_P3    = 6'd38,
                          S_P4    = 6'd39, S_P5    = 6'd40;

   // who called the coalesce routine
   localparam logic [1:0] CTX_INIT = 2'd0, CTX_FREE = 2'd1, CTX_ALLOC = 2'd2;

   logic [5:0]    state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [16:0]   brk_ff, brk_in;
   logic [16:0]   chunk_ff, limit_ff;
   logic [1:0]    ctx_ff, ctx_in;
   logic [33:0]   srch_ff, srch_in;
   logic [31:0]   bp_ff, bp_in;
   logic [16:0]   asize_ff, asize_in;
   logic [31:0]   gsz_ff, gsz_in;
   logic [31:0]   psz_ff, psz_in;
   logic [31:0]   h1_ff, h1_in;
   logic [31:0]   sz_ff, sz_in;
   logic [31:0]   nb_ff, nb_in;
   logic [31:0]   pb_ff, pb_in;
   logic          pa_ff, pa_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [15:0]   rsp_off_ff, rsp_off_in;
   logic [1:0]    rsp_st_ff, rsp_st_in;

   bhtag_pkg::tag_cmd_type mem_cmd;
   logic [31:0]   mem_off;
   logic [31:0]   mem_wdata;
   logic [31:0]   mem_rdata;
   logic [31:0]   rdsz;
   logic          req_acc;

   // request decode and growth sizing
   logic [16:0]   req_sum;
   logic [16:0]   req_asize;
   logic [16:0]   ext;
   logic [15:0]   wsum;
   logic [17:0]   grow_sz;
   logic [16:0]   eff_lim;
   logic          grow_fits;

   bhtag_ram #(.DEPTH(TAG_DEPTH), .AW(AW)) u_ram (
      .clock (clock),
      .cmd   (mem_cmd),
      .addr  (mem_off[AW+1:2]),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   assign rdsz      = bhtag_pkg::tsize(mem_rdata);
   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign req_acc   = req_valid && req_ready;

   assign req_sum   = {1'b0, req_request_bytes} + 17'd15;
   assign req_asize = (req_request_bytes <= 16'd8) ? 17'd16 : {req_sum[16:3], 3'b000};

   assign ext       = (asize_ff > chunk_ff) ? asize_ff : chunk_ff;
   assign wsum      = {1'b0, ext[16:2]} + {15'b0, ext[2]};
   assign grow_sz   = {wsum, 2'b00};
   assign eff_lim   = (limit_ff > 17'(LIM_CAP)) ? 17'(LIM_CAP) : limit_ff;
   assign grow_fits = ({2'b00, brk_ff} + {1'b0, grow_sz}) <= {2'b00, eff_lim};

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      brk_in       = brk_ff;
      ctx_in       = ctx_ff;
      srch_in      = srch_ff;
      bp_in        = bp_ff;
      asize_in     = asize_ff;
      gsz_in       = gsz_ff;
      psz_in       = psz_ff;
      h1_in        = h1_ff;
      sz_in        = sz_ff;
      nb_in        = nb_ff;
      pb_in        = pb_ff;
      pa_in        = pa_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_off_in   = rsp_off_ff;
      rsp_st_in    = rsp_st_ff;
      mem_cmd      = '0;
      mem_off      = '0;
      mem_wdata    = '0;

      unique case (state_ff)
         S_CLEAR: begin
            mem_cmd.write = 1'b1;
            mem_off       = 32'({clr_ff, 2'b00});
            clr_in        = clr_ff + AW'(1);
            if (clr_ff == AW'(TAG_DEPTH - 1)) begin
               state_in = S_INIT1;
            end
         end
         S_INIT1: begin
            mem_cmd.write = 1'b1;
            mem_off       = 32'd4;
            mem_wdata     = 32'd9;
            state_in      = S_INIT2;
         end
         S_INIT2: begin
            mem_cmd.write = 1'b1;
            mem_off       = 32'd8;
            mem_wdata     = 32'd9;
            state_in      = S_INIT3;
         end
         S_INIT3: begin
            mem_cmd.write = 1'b1;
            mem_off       = 32'd12;
            mem_wdata     = 32'd1;
            brk_in        = 17'd16;
            gsz_in        = 32'(INIT_SIZE);
            ctx_in        = CTX_INIT;
            state_in      = INIT_GROW ? S_G0 : S_IDLE;
         end
         S_IDLE: begin
            if (req_acc) begin
               if (req_opcode == bhtag_pkg::OP_FREE) begin
                  bp_in = {16'b0, req_block_offset};
                  if (req_block_offset == 16'd0) begin
                     rsp_valid_in = 1'b1;
                     rsp_off_in   = 16'd0;
                     rsp_st_in    = bhtag_pkg::ST_DONE;
                  end else begin
                     state_in = S_F0;
                  end
               end else if (req_request_bytes == 16'd0) begin
                  rsp_valid_in = 1'b1;
                  rsp_off_in   = 16'd0;
                  rsp_st_in    = bhtag_pkg::ST_ZERO;
               end else begin
                  asize_in = req_asize;
                  srch_in  = 34'd8;
                  state_in = S_FIT;
               end
            end
         end
         // free: clear the allocated bit in header and footer
         S_F0: begin
            mem_cmd.read = 1'b1;
            mem_off      = bp_ff - 32'd4;
            state_in     = S_F1;
         end
         S_F1: begin
            mem_cmd.write = 1'b1;
            mem_off       = bp_ff - 32'd4;
            mem_wdata     = rdsz;
            sz_in         = rdsz;
            state_in      = S_F2;
         end
         S_F2: begin
            mem_cmd.write = 1'b1;
            mem_off       = bp_ff + sz_ff - 32'd8;
            mem_wdata     = sz_ff;
            ctx_in        = CTX_FREE;
            state_in      = S_M0;
         end
         // first-fit walk, one header per read
         S_FIT: begin
            if (srch_ff >= {17'b0, brk_ff}) begin
               state_in = S_EXT;
            end else begin
               mem_cmd.read = 1'b1;
               mem_off      = srch_ff[31:0] - 32'd4;
               state_in     = S_FIT1;
            end
         end
         S_FIT1: begin
            if (rdsz == 32'd0) begin
               state_in = S_EXT;
            end else if (!mem_rdata[0] && ({15'b0, asize_ff} <= rdsz)) begin
               bp_in    = srch_ff[31:0];
               state_in = S_P0;
            end else begin
               srch_in  = srch_ff + {2'b00, rdsz};
               state_in = S_FIT;
            end
         end
         S_EXT: begin
            if (grow_fits) begin
               gsz_in   = {14'b0, grow_sz};
               ctx_in   = CTX_ALLOC;
               state_in = S_G0;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_off_in   = 16'd0;
               rsp_st_in    = bhtag_pkg::ST_NOMEM;
               state_in     = S_IDLE;
            end
         end
         // grow the break: new free block plus fresh epilogue
         S_G0: begin
            mem_cmd.write = 1'b1;
            mem_off       = {15'b0, brk_ff} - 32'd4;
            mem_wdata     = gsz_ff;
            state_in      = S_G1;
         end
         S_G1: begin
            mem_cmd.write = 1'b1;
            mem_off       = {15'b0, brk_ff} + gsz_ff - 32'd8;
            mem_wdata     = gsz_ff;
            state_in      = S_G2;
         end
         S_G2: begin
            mem_cmd.write = 1'b1;
            mem_off       = {15'b0, brk_ff} + gsz_ff - 32'd4;
            mem_wdata     = 32'd1;
            bp_in         = {15'b0, brk_ff};
            brk_in        = brk_ff + gsz_ff[16:0];
            state_in      = S_M0;
         end
         // coalesce: read neighbor tags
         S_M0: begin
            mem_cmd.read = 1'b1;
            mem_off      = bp_ff - 32'd8;
            state_in     = S_M1;
         end
         S_M1: begin
            pa_in        = mem_rdata[0];
            psz_in       = rdsz;
            mem_cmd.read = 1'b1;
            mem_off      = bp_ff - 32'd4;
            state_in     = S_M2;
         end
         S_M2: begin
            h1_in        = rdsz;
            mem_cmd.read = 1'b1;
            mem_off      = bp_ff + rdsz - 32'd4;
            state_in     = S_M3;
         end
         S_M3: begin
            nb_in = bp_ff + h1_ff;
            pb_in = bp_ff - psz_ff;
            if (pa_ff && mem_rdata[0]) begin
               state_in = S_MRET;
            end else if (pa_ff) begin
               state_in = S_A0;
            end else if (mem_rdata[0]) begin
               state_in = S_B0;
            end else begin
               state_in = S_C0;
            end
         end
         // next block free
         S_A0: begin
            mem_cmd.read = 1'b1;
            mem_off      = nb_ff - 32'd4;
            state_in     = S_A1;
         end
         S_A1: begin
            sz_in         = h1_ff + rdsz;
            mem_cmd.write = 1'b1;
            mem_off       = bp_ff - 32'd4;
            mem_wdata     = bhtag_pkg::tsize(h1_ff + rdsz);
            state_in      = S_A2;
         end
         S_A2: begin
            mem_cmd.write = 1'b1;
            mem_off       = bp_ff + bhtag_pkg::tsize(sz_ff) - 32'd8;
            mem_wdata     = bhtag_pkg::tsize(sz_ff);
            state_in      = S_MRET;
         end
         // previous block free
         S_B0: begin
            mem_cmd.read = 1'b1;
            mem_off      = pb_ff - 32'd4;
            state_in     = S_B1;
         end
         S_B1: begin
            sz_in         = h1_ff + rdsz;
            mem_cmd.write = 1'b1;
            mem_off       = bp_ff + h1_ff - 32'd8;
            mem_wdata     = bhtag_pkg::tsize(h1_ff + rdsz);
            state_in      = S_B2;
         end
         S_B2: begin
            mem_cmd.read = 1'b1;
            mem_off      = bp_ff - 32'd8;
            state_in     = S_B3;
         end
         S_B3: begin
            mem_cmd.write = 1'b1;
            mem_off       = bp_ff - rdsz - 32'd4;
            mem_wdata     = bhtag_pkg::tsize(sz_ff);
            state_in      = S_B4;
         end
         S_B4: begin
            mem_cmd.read = 1'b1;
            mem_off      = bp_ff - 32'd8;
            state_in     = S_B5;
         end
         S_B5: begin
            bp_in    = bp_ff - rdsz;
            state_in = S_MRET;
         end
         // both neighbors free
         S_C0: begin
            mem_cmd.read = 1'b1;
            mem_off      = pb_ff - 32'd4;
            state_in     = S_C1;
         end
         S_C1: begin
            sz_in        = h1_ff + rdsz;
            mem_cmd.read = 1'b1;
            mem_off      = nb_ff - 32'd4;
            state_in     = S_C2;
         end
         S_C2: begin
            mem_cmd.read = 1'b1;
            mem_off      = nb_ff + rdsz - 32'd8;
            state_in     = S_C3;
         end
         S_C3: begin
            sz_in         = sz_ff + rdsz;
            mem_cmd.write = 1'b1;
            mem_off       = pb_ff - 32'd4;
            mem_wdata     = bhtag_pkg::tsize(sz_ff + rdsz);
            state_in      = S_C4;
         end
         S_C4: begin
            mem_cmd.read = 1'b1;
            mem_off      = bp_ff - 32'd4;
            state_in     = S_C5;
         end
         S_C5: begin
            nb_in        = bp_ff + rdsz;
            mem_cmd.read = 1'b1;
            mem_off      = bp_ff + rdsz - 32'd4;
            state_in     = S_C6;
         end
         S_C6: begin
            mem_cmd.write = 1'b1;
            mem_off       = nb_ff + rdsz - 32'd8;
            mem_wdata     = bhtag_pkg::tsize(sz_ff);
            state_in      = S_B4;
         end
         S_MRET: begin
            if (ctx_ff == CTX_ALLOC) begin
               state_in = S_P0;
            end else if (ctx_ff == CTX_FREE) begin
               rsp_valid_in = 1'b1;
               rsp_off_in   = 16'd0;
               rsp_st_in    = bhtag_pkg::ST_DONE;
               state_in     = S_IDLE;
            end else begin
               state_in = S_IDLE;
            end
         end
         // place the block, splitting off a free remainder when it is big enough
         S_P0: begin
            mem_cmd.read = 1'b1;
            mem_off      = bp_ff - 32'd4;
            state_in     = S_P1;
         end
         S_P1: begin
            mem_cmd.write = 1'b1;
            mem_off       = bp_ff - 32'd4;
            if ((rdsz >= {15'b0, asize_ff}) &&
                ((rdsz - {15'b0, asize_ff}) >= 32'(bhtag_pkg::MIN_BLOCK))) begin
               mem_wdata = {15'b0, asize_ff} | 32'd1;
               sz_in     = rdsz - {15'b0, asize_ff};
               state_in  = S_P2;
            end else begin
               mem_wdata = rdsz | 32'd1;
               sz_in     = rdsz;
               state_in  = S_P5;
            end
         end
         S_P2: begin
            mem_cmd.write = 1'b1;
            mem_off       = bp_ff + {15'b0, asize_ff} - 32'd8;
            mem_wdata     = {15'b0, asize_ff} | 32'd1;
            state_in      = S_P3;
         end
         S_P3: begin
            mem_cmd.write = 1'b1;
            mem_off       = bp_ff + {15'b0, asize_ff} - 32'd4;
            mem_wdata     = sz_ff;
            state_in      = S_P4;
         end
         S_P4: begin
            mem_cmd.write = 1'b1;
            mem_off       = bp_ff + {15'b0, asize_ff} + sz_ff - 32'd8;
            mem_wdata     = sz_ff;
            rsp_valid_in  = 1'b1;
            rsp_off_in    = bp_ff[15:0];
            rsp_st_in     = bhtag_pkg::ST_DONE;
            state_in      = S_IDLE;
         end
         S_P5: begin
            mem_cmd.write = 1'b1;
            mem_off       = bp_ff + sz_ff - 32'd8;
            mem_wdata     = sz_ff | 32'd1;
            rsp_valid_in  = 1'b1;
            rsp_off_in    = bp_ff[15:0];
            rsp_st_in     = bhtag_pkg::ST_DONE;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         brk_ff       <= 17'd16;
         ctx_ff       <= CTX_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         brk_ff       <= brk_in;
         ctx_ff       <= ctx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      srch_ff    <= srch_in;
      bp_ff      <= bp_in;
      asize_ff   <= asize_in;
      gsz_ff     <= gsz_in;
      psz_ff     <= psz_in;
      h1_ff      <= h1_in;
      sz_ff      <= sz_in;
      nb_ff      <= nb_in;
      pb_ff      <= pb_in;
      pa_ff      <= pa_in;
      rsp_off_ff <= rsp_off_in;
      rsp_st_ff  <= rsp_st_in;
   end

   // configuration registers; writes never rebuild the heap
   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_ff <= 17'(bhtag_pkg::CHUNK_RESET);
         limit_ff <= 17'(bhtag_pkg::LIMIT_RESET);
      end else if (csr_we) begin
         unique case (csr_index)
            bhtag_pkg::CSR_CHUNK: chunk_ff <= csr_wdata;
            bhtag_pkg::CSR_LIMIT: limit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_offset = rsp_off_ff;
   assign rsp_status        = rsp_st_ff;

   // a waiting response only ever sits while the sequencer is parked
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == S_IDLE))
      else $error("response pending while sequencer busy");

   // the break never passes the addressable cap
   a_brk_cap: assert property (@(posedge clock) disable iff (reset)
      brk_ff <= 17'(LIM_CAP))
      else $error("break beyond heap cap");

   // an accepted request either produces a response or starts work
   a_acc_prog: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (rsp_valid_ff || (state_ff != S_IDLE)))
      else $error("accepted request dropped");

   // a failed or zero-size allocate never reports an offset
   a_zero_off: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_st_ff != bhtag_pkg::ST_DONE)) |-> (rsp_off_ff == 16'd0))
      else $error("offset on failed request");
endmodule
